// File: src/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: src/rrf_pkg.sv
// -----------------------------------------------------------------------------
// rrf_pkg
// Shared types and constants for the rank fusion block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rrf_pkg;
    localparam logic [1:0] KIND_SPARSE = 2'd0;
    localparam logic [1:0] KIND_DENSE  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [0:0] REG_RANK_OFFSET  = 1'b0;
    localparam logic [0:0] REG_RESULT_COUNT = 1'b1;
    localparam int SCORE_W = 26;
    // Fraction bits of the fused score; the score width above assumes Q2.24.
    localparam int FRAC_BITS = 24;

    // Divider control handed to the reciprocal unit.
    typedef struct packed {
        logic        start;
        logic [12:0] denom;
    } t_div_req;
endpackage

// File: src/rrf_div.sv
// -----------------------------------------------------------------------------
// rrf_div
// Restoring divider: computes 2^FRAC_BITS / denom, one quotient bit per cycle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rrf_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrf_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [FRAC_BITS:0] o_quot
);
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);
    logic [QW-1:0] r_quot, n_quot;
    logic [QW-1:0] r_num, n_num;
    logic [13:0]   r_rem, n_rem;
    logic [12:0]   r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, r_done;
    logic [13:0]   w_sh;

    always_comb begin
        w_sh   = {r_rem[12:0], r_num[QW-1]};
        n_num  = {r_num[QW-2:0], 1'b0};
        n_rem  = w_sh;
        n_quot = {r_quot[QW-2:0], 1'b0};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem  = w_sh - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
        n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_num  <= QW'(1) << FRAC_BITS;
            r_rem  <= '0;
            r_quot <= '0;
            r_den  <= i_req.denom;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_cnt  <= n_cnt;
        end
    end
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// File: src/reciprocal_rank_fusion_top_k.sv
// -----------------------------------------------------------------------------
// reciprocal_rank_fusion_top_k
// Reciprocal rank fusion of a sparse and a dense ranked list with top-k output.
// -----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[31:0] doc_id, tuser[1:0] kind
// m_axis    out  tdata[31:0] doc_id_res, [57:32] score; tlast last;
//                tuser[0] empty_res, tuser[1] overflow
// cfg       in   index 0 rank_offset, 1 result_count
//
// A list entry scans the id table one entry per cycle while the reciprocal
// divider runs; the entry takes the longer of the two plus the
// read-modify-write of the table entry.
// A finish on a non-empty table runs min(result_count, MAX_TOP, entry_count) + 1
// selection passes, each a table scan and all but the last with an output step,
// then clears the count registers. Reset is synchronous, active low, and needs
// no clearing pass: table entries past entry_count are never read. Output stalls
// hold the result register and the selection waits.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module reciprocal_rank_fusion_top_k #(
    parameter int MAX_DOCS  = 256,
    parameter int MAX_LIST  = 256,
    parameter int MAX_TOP   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // doc_id
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tlast,   // last
    output logic [63:0] m_axis_tdata,   // doc_id_res, score, zero fill
    output logic [1:0]  m_axis_tuser,   // empty_res, overflow
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    localparam int FRAC_BITS = rrf_pkg::FRAC_BITS;
    localparam int AW = $clog2(MAX_DOCS);
    localparam int CW = AW + 1;
    localparam int LW = $clog2(MAX_LIST + 1);
    localparam int SW = rrf_pkg::SCORE_W;
    localparam logic [SW-1:0] SMAX = '1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_WAITD = 9'b000000100,
        S_RD    = 9'b000001000,
        S_WR    = 9'b000010000,
        S_SEL   = 9'b000100000,
        S_PICK  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;
    t_state r_state;

    // Table memories: id, score and a used mark for top-k selection.
    logic [31:0]   id_mem [MAX_DOCS];
    logic [SW-1:0] sc_mem [MAX_DOCS];
    logic          used_mem [MAX_DOCS];
    logic [31:0]   r_id_q;
    logic [SW-1:0] r_sc_q;
    logic          r_used_q;

    logic [9:0]    r_offset;
    logic [6:0]    r_rcount;
    logic [CW-1:0] r_count;
    logic [LW-1:0] r_srank, r_drank;
    logic          r_drop;
    logic [31:0]   r_id;
    logic [CW-1:0] r_idx;
    logic          r_rd_valid;
    logic [AW-1:0] r_rd_addr;
    logic          r_found;
    logic [AW-1:0] r_hit;
    logic          r_div_ok;
    logic [FRAC_BITS:0] r_gain;
    logic [6:0]    r_want, r_k;
    logic          r_best_v;
    logic [AW-1:0] r_best;
    logic [SW-1:0] r_best_sc;
    logic [31:0]   r_best_id;
    logic          r_mv;
    logic [63:0]   r_md;
    logic [1:0]    r_mu;
    logic          r_ml;

    rrf_pkg::t_div_req w_div;
    logic              w_div_done;
    logic [FRAC_BITS:0] w_quot;
    rrf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_div),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    logic          w_acc;
    logic [LW-1:0] w_rank;
    logic [SW:0]   w_sum;
    logic [6:0]    w_want;
    logic [AW-1:0] w_ra;
    logic          w_re;
    logic          w_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_rank = s_axis_tuser[0] ? r_drank : r_srank;
    assign w_sum  = {1'b0, r_sc_q} + (SW+1)'(r_gain);

    // The output register takes a new item when it is free or being drained.
    assign w_load = ((r_state == S_OUT) || (r_state == S_EMIT && r_count == '0))
                    && (!r_mv || m_axis_tready);

    always_comb begin
        w_want = r_rcount;
        if (w_want > 7'(MAX_TOP)) w_want = 7'(MAX_TOP);
        if (int'(r_count) < int'(w_want))
            w_want = 7'(r_count);
    end

    assign w_div.start = w_acc && (s_axis_tuser == rrf_pkg::KIND_SPARSE
                         || s_axis_tuser == rrf_pkg::KIND_DENSE) && (w_rank < LW'(MAX_LIST));
    assign w_div.denom = 13'(r_offset) + 13'(w_rank) + 13'd1;

    // Memory read port: scan address during search and selection, hit on update.
    assign w_re = (r_state == S_SCAN || r_state == S_SEL) && (r_idx < r_count);
    assign w_ra = (r_state == S_RD) ? r_hit : r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_rd_valid <= w_re;
        r_rd_addr  <= w_ra;
        r_id_q     <= id_mem[w_ra];
        r_sc_q     <= sc_mem[w_ra];
        r_used_q   <= used_mem[w_ra];
        if (r_state == S_WR) begin
            id_mem[r_hit]   <= r_id;
            sc_mem[r_hit]   <= r_found ? (w_sum[SW] ? SMAX : w_sum[SW-1:0])
                                       : SW'(r_gain);
            used_mem[r_hit] <= 1'b0;
        end else if (r_state == S_OUT && (m_axis_tready || !r_mv)) begin
            used_mem[r_best] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_offset <= 10'd60;
            r_rcount <= 7'd10;
            r_count  <= '0;
            r_srank  <= '0;
            r_drank  <= '0;
            r_drop   <= 1'b0;
            r_mv     <= 1'b0;
            r_div_ok <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && !w_load) r_mv <= 1'b0;
            if (w_div_done) begin
                r_div_ok <= 1'b1;
                r_gain   <= w_quot;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == rrf_pkg::REG_RANK_OFFSET) r_offset <= i_cfg_data;
                else r_rcount <= i_cfg_data[6:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_id    <= s_axis_tdata;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_div_ok <= 1'b0;
                        if (w_div.start) begin
                            if (s_axis_tuser[0]) r_drank <= r_drank + LW'(1);
                            else r_srank <= r_srank + LW'(1);
                            r_state <= S_SCAN;
                        end else if (s_axis_tuser == rrf_pkg::KIND_SPARSE
                                     || s_axis_tuser == rrf_pkg::KIND_DENSE) begin
                            r_drop <= 1'b1;
                        end else if (s_axis_tuser == rrf_pkg::KIND_FINISH) begin
                            r_want <= w_want;
                            r_k    <= '0;
                            r_state <= (r_count == '0) ? S_EMIT : S_SEL;
                            r_best_v <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rd_valid && r_id_q == r_id) begin
                        r_found <= 1'b1;
                        r_hit   <= r_rd_addr;
                        r_state <= S_WAITD;
                    end else if (r_idx < r_count) begin
                        r_idx <= r_idx + CW'(1);
                    end else if (!r_rd_valid) begin
                        if (r_count >= CW'(MAX_DOCS)) begin
                            r_drop  <= 1'b1;
                            r_state <= S_WAITD;
                            r_found <= 1'b1;
                            r_hit   <= '0;
                            r_idx   <= '1;
                        end else begin
                            r_hit   <= r_count[AW-1:0];
                            r_state <= S_WAITD;
                        end
                    end
                end
                S_WAITD: begin
                    if (r_div_ok || w_div_done) begin
                        if (r_idx == '1 && r_found) r_state <= S_IDLE;
                        else r_state <= r_found ? S_RD : S_WR;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    if (!r_found) r_count <= r_count + CW'(1);
                    r_state <= S_IDLE;
                end
                S_SEL: begin
                    if (r_rd_valid && !r_used_q
                        && (!r_best_v || r_sc_q > r_best_sc)) begin
                        r_best_v  <= 1'b1;
                        r_best    <= r_rd_addr;
                        r_best_sc <= r_sc_q;
                        r_best_id <= r_id_q;
                    end
                    if (r_idx < r_count) r_idx <= r_idx + CW'(1);
                    else if (!r_rd_valid) r_state <= (r_k < r_want) ? S_OUT : S_EMIT;
                end
                S_OUT: begin
                    if (!r_mv || m_axis_tready) begin
                        r_mv <= 1'b1;
                        r_md <= {6'd0, r_best_sc, r_best_id};
                        r_mu <= {r_drop, 1'b0};
                        r_ml <= (r_k + 7'd1 == r_want);
                        r_k  <= r_k + 7'd1;
                        r_best_v <= 1'b0;
                        r_idx <= '0;
                        r_state <= S_SEL;
                    end
                end
                S_EMIT: begin
                    if (!r_mv || m_axis_tready) begin
                        if (r_count == '0) begin
                            r_mv <= 1'b1;
                            r_md <= '0;
                            r_mu <= {r_drop, 1'b1};
                            r_ml <= 1'b1;
                        end
                        r_count <= '0;
                        r_srank <= '0;
                        r_drank <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_md;
    assign m_axis_tuser  = r_mu;
    assign m_axis_tlast  = r_ml;
endmodule

// File: src/rrf_checker.sv
// -----------------------------------------------------------------------------
// rrf_checker
// Port-level checks on the fusion block, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic        m_axis_tlast,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    logic w_empty;
    logic w_stall;

    assign w_empty = m_axis_tvalid && m_axis_tuser[0];
    assign w_stall = m_axis_tvalid && !m_axis_tready;

    `ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, w_empty, m_axis_tdata == 64'd0)
    `ASSERT_IMPL(a_empty_last, i_clk, i_rst_n, w_empty, m_axis_tlast)
    `ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[63:58] == 6'd0)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind reciprocal_rank_fusion_top_k rrf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// File: tb/reciprocal_rank_fusion_top_k_tb.sv
// -----------------------------------------------------------------------------
// reciprocal_rank_fusion_top_k_tb
// Self-checking bench for the rank fusion block. Sparse and dense list entries
// and finish items are streamed in with random gaps. A scoreboard keeps its own
// copy of the fused-score table and predicts each ranked result. Covered:
// extreme ids, ties, saturation, a full table, an overlong list, empty and
// zero-count finishes, an unused kind, a long output stall, and random lists.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module reciprocal_rank_fusion_top_k_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 256;
    localparam int LIST_DEPTH  = 256;
    localparam int TOP_LIMIT   = 64;
    localparam logic [25:0] SCORE_SAT = 26'h3FF_FFFF;
    // The longest quiet stretch is the long receiver hold or the settling
    // wait before a register write, each well below STALL_LIMIT.
    localparam int STALL_LIMIT = 5000;
    // Settling time after the last result, longer than one list entry takes.
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [31:0] doc_id;
        logic [25:0] score;
        logic        last;
        logic        empty;
        logic        ovf;
    } fused_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        m_axis_tlast;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [9:0]  i_cfg_data;

    reciprocal_rank_fusion_top_k uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Scoreboard copy of the block's state and registers.
    logic [31:0] id_tab [TABLE_DEPTH];
    logic [25:0] score_tab [TABLE_DEPTH];
    int          doc_count;
    int          list_rank [2];
    logic        dropped;
    logic [9:0]  k_offset;
    logic [6:0]  top_count;
    fused_t      ranked_q [$];

    int error_count;
    int items_sent;
    int results_seen;
    int finishes_sent;
    int idle_cycles;
    bit no_idle;
    int rx_wait;
    int rx_hold;

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    function automatic void clear_lists();
        doc_count = 0;
        list_rank[0] = 0;
        list_rank[1] = 0;
        dropped = 1'b0;
    endfunction

    // Appends one predicted result to the expectation queue.
    function automatic void expect_result(input fused_t res);
        ranked_q = {ranked_q, res};
    endfunction

    // One list entry: reciprocal gain into the distinct-id table.
    function automatic void fuse_entry(input int lst, input logic [31:0] id);
        int r;
        int slot;
        logic [63:0] gain;
        logic [63:0] sum;
        r = list_rank[lst];
        if (r >= LIST_DEPTH) begin
            dropped = 1'b1;
            return;
        end
        list_rank[lst] = r + 1;
        gain = (64'd1 << 24) / (64'(k_offset) + 64'(r) + 64'd1);
        slot = doc_count;
        for (int i = 0; i < doc_count; i++) begin
            if (id_tab[i] == id) begin
                slot = i;
                break;
            end
        end
        if (slot == doc_count) begin
            if (doc_count >= TABLE_DEPTH) begin
                dropped = 1'b1;
                return;
            end
            id_tab[slot] = id;
            score_tab[slot] = '0;
            doc_count++;
        end
        sum = 64'(score_tab[slot]) + gain;
        score_tab[slot] = (sum > 64'(SCORE_SAT)) ? SCORE_SAT : sum[25:0];
    endfunction

    // Finish: queue the top documents, earlier first appearance wins ties.
    function automatic void rank_documents();
        bit     taken [TABLE_DEPTH];
        int     want;
        int     best;
        fused_t res;
        if (doc_count == 0) begin
            res = '{doc_id: '0, score: '0, last: 1'b1, empty: 1'b1, ovf: dropped};
            expect_result(res);
            clear_lists();
            return;
        end
        want = top_count;
        if (want > TOP_LIMIT) want = TOP_LIMIT;
        if (want > doc_count) want = doc_count;
        for (int i = 0; i < TABLE_DEPTH; i++) taken[i] = 1'b0;
        for (int k = 0; k < want; k++) begin
            best = -1;
            for (int i = 0; i < doc_count; i++) begin
                if (!taken[i] && (best < 0 || score_tab[i] > score_tab[best])) best = i;
            end
            taken[best] = 1'b1;
            res.doc_id = id_tab[best];
            res.score  = score_tab[best];
            res.last   = (k + 1 == want);
            res.empty  = 1'b0;
            res.ovf    = dropped;
            expect_result(res);
        end
        clear_lists();
    endfunction

    function automatic void predict_item(input logic [1:0] kind, input logic [31:0] id);
        case (kind)
            rrf_pkg::KIND_SPARSE: fuse_entry(0, id);
            rrf_pkg::KIND_DENSE:  fuse_entry(1, id);
            rrf_pkg::KIND_FINISH: rank_documents();
            default: ;
        endcase
    endfunction

    // Sends one item. Valid stays high from one item to the next when there
    // is no gap, so it is never dropped and raised in the same time step.
    task automatic send_item(input logic [1:0] kind, input logic [31:0] id);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= id;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(kind, id);
        items_sent++;
        if (kind == rrf_pkg::KIND_FINISH) finishes_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Registers are only written once every result is out and the block
    // has had time to finish any list entry still in flight.
    task automatic write_reg(input logic idx, input logic [9:0] value);
        stop_sending();
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == rrf_pkg::REG_RANK_OFFSET) k_offset = value;
        else top_count = value[6:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [9:0] offset, input logic [9:0] count);
        write_reg(rrf_pkg::REG_RANK_OFFSET, offset);
        write_reg(rrf_pkg::REG_RESULT_COUNT, count);
    endtask

    // Receiver: a random wait per item, or a long hold when requested.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_axis_tready <= i_rst_n;
        end
    end

    // Result checker, sampled at the rising edge.
    always @(posedge i_clk) begin
        fused_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            rx_wait = no_idle ? 0 : $urandom_range(0, 9);
            if (ranked_q.size() == 0) begin
                $display("%0t: result with no expectation pending, doc 0x%0h", $time,
                         m_axis_tdata[31:0]);
                error_count++;
            end else begin
                want = ranked_q.pop_front();
                if (m_axis_tdata[31:0] !== want.doc_id)
                    report("doc_id_res", 64'(m_axis_tdata[31:0]), 64'(want.doc_id));
                if (m_axis_tdata[57:32] !== want.score)
                    report("score", 64'(m_axis_tdata[57:32]), 64'(want.score));
                if (m_axis_tlast !== want.last)
                    report("last", 64'(m_axis_tlast), 64'(want.last));
                if (m_axis_tuser[0] !== want.empty)
                    report("empty_res", 64'(m_axis_tuser[0]), 64'(want.empty));
                if (m_axis_tuser[1] !== want.ovf)
                    report("overflow", 64'(m_axis_tuser[1]), 64'(want.ovf));
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles with no handshake", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Extreme ids in both lists, an unused kind that must be ignored.
    task automatic test_extreme_ids();
        set_config(10'd60, 10'd10);
        send_item(rrf_pkg::KIND_SPARSE, 32'h0000_0000);
        send_item(rrf_pkg::KIND_SPARSE, 32'hFFFF_FFFF);
        send_item(KIND_UNUSED, 32'h1234_5678);
        send_item(rrf_pkg::KIND_DENSE, 32'hFFFF_FFFF);
        send_item(rrf_pkg::KIND_DENSE, 32'hA5A5_5A5A);
        send_item(rrf_pkg::KIND_FINISH, 32'hDEAD_BEEF);
    endtask

    // Finish with nothing held, and a zero result count that still clears.
    task automatic test_empty_finishes();
        send_item(rrf_pkg::KIND_FINISH, 32'h0);
        set_config(10'd60, 10'd0);
        send_item(rrf_pkg::KIND_SPARSE, 32'h11);
        send_item(rrf_pkg::KIND_DENSE, 32'h22);
        send_item(rrf_pkg::KIND_FINISH, 32'h0);
        send_item(rrf_pkg::KIND_FINISH, 32'h0);
    endtask

    // Equal scores resolve to the earlier id; count above the limit clips.
    task automatic test_ties();
        set_config(10'd1023, 10'd127);
        send_item(rrf_pkg::KIND_SPARSE, 32'h0000_0AAA);
        send_item(rrf_pkg::KIND_DENSE, 32'h0000_0BBB);
        send_item(rrf_pkg::KIND_FINISH, 32'h0);
    endtask

    // Repeats of one id in both lists with a zero offset saturate the score.
    task automatic test_saturation();
        set_config(10'd0, 10'd1);
        for (int i = 0; i < 12; i++) begin
            send_item(rrf_pkg::KIND_SPARSE, 32'h0C0F_FEE0);
            send_item(rrf_pkg::KIND_DENSE, 32'h0C0F_FEE0);
        end
        send_item(rrf_pkg::KIND_FINISH, 32'h0);
    endtask

    // Fill the table, then overrun it and overrun the sparse list.
    task automatic test_capacity();
        set_config(10'd1023, 10'd64);
        for (int i = 0; i < TABLE_DEPTH; i++) send_item(rrf_pkg::KIND_SPARSE, 32'h100 + i);
        send_item(rrf_pkg::KIND_DENSE, 32'hFFFF_0000);
        send_item(rrf_pkg::KIND_DENSE, 32'h100);
        send_item(rrf_pkg::KIND_SPARSE, 32'h105);
        send_item(rrf_pkg::KIND_FINISH, 32'h0);
    endtask

    // The receiver holds off while items keep coming, so the input stalls.
    task automatic test_output_stall();
        set_config(10'd5, 10'd8);
        no_idle = 1'b1;
        for (int i = 0; i < 10; i++) send_item(rrf_pkg::KIND_SPARSE, $urandom_range(0, 5));
        rx_hold = 600;
        send_item(rrf_pkg::KIND_FINISH, 32'h0);
        for (int i = 0; i < 10; i++) send_item(rrf_pkg::KIND_DENSE, $urandom);
        send_item(rrf_pkg::KIND_FINISH, 32'h0);
        no_idle = 1'b0;
    endtask

    // Random list pairs over a small id pool so ids repeat, with some noise.
    task automatic test_random_lists();
        logic [31:0] pool [8];
        logic [1:0]  kind;
        logic [31:0] id;
        int          count;
        int          sel;
        int          sets;
        sets = 0;
        count = 0;
        while (count < 60) begin
            sel = $urandom_range(0, 3);
            set_config(sel == 0 ? 10'd0 : sel == 1 ? 10'd1023 : 10'($urandom_range(0, 1023)),
                       $urandom_range(0, 5) == 0 ? 10'($urandom_range(0, 1023))
                                                 : 10'($urandom_range(1, 12)));
            no_idle = (sets % 4 == 3);
            foreach (pool[i]) pool[i] = $urandom;
            if ($urandom_range(0, 7) != 0) begin
                repeat ($urandom_range(1, 20)) begin
                    kind = ($urandom_range(0, 19) == 0) ? KIND_UNUSED
                                                        : 2'($urandom_range(0, 1));
                    id = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 7)];
                    send_item(kind, id);
                    if (kind != KIND_UNUSED) count++;
                end
            end
            send_item(rrf_pkg::KIND_FINISH, $urandom);
            count++;
            sets++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = rrf_pkg::KIND_SPARSE;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = rrf_pkg::REG_RANK_OFFSET;
        i_cfg_data    = '0;
        error_count   = 0;
        items_sent    = 0;
        results_seen  = 0;
        finishes_sent = 0;
        idle_cycles   = 0;
        no_idle       = 1'b0;
        rx_wait       = 0;
        rx_hold       = 0;
        k_offset      = 10'd60;
        top_count     = 7'd10;
        clear_lists();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extreme_ids();
        test_empty_finishes();
        test_ties();
        test_saturation();
        test_capacity();
        test_output_stall();
        test_random_lists();

        stop_sending();
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items including %0d finishes; checked %0d ranked results.",
                 items_sent, finishes_sent, results_seen);
        $display("Covered ties, saturation, full table, long list, empty and stalled output.");
        if (error_count == 0 && ranked_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", error_count,
                     ranked_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
